// ===== rtl/bmb_pkg.sv =====
// Package for the broadcast message buffer: sizes, codes and the cell slot type.
// Depends on nothing; used by every module under rtl.
package bmb_pkg;
   localparam int QueueDepth    = 16;
   localparam int ConsumerCount = 16;
   localparam int SlotW         = $clog2(QueueDepth);
   localparam int CountW        = $clog2(QueueDepth + 1);

   localparam logic [1:0] KIND_ENQ  = 2'd0;
   localparam logic [1:0] KIND_DLV  = 2'd1;
   localparam logic [1:0] KIND_NONE = 2'd2;

   localparam logic       ACT_ENQ   = 1'b0;
   localparam logic       ACT_FETCH = 1'b1;

   localparam logic       REG_MAX_MESSAGES = 1'b0;
   localparam logic       REG_MAX_OFFSET   = 1'b1;

   // one held message as it travels round the ring
   typedef struct packed {
      logic [7:0]               topic;
      logic [31:0]              payload;
      logic [31:0]              offset;
      logic [ConsumerCount-1:0] seen;
   } msg_type;

   // what the sequencer tells every cell in a rotation step
   typedef struct packed {
      logic       shift;
      logic       mark;
      logic [3:0] consumer;
      logic [7:0] topic;
   } cell_ctl_type;
endpackage

// ===== rtl/bmb_cell.sv =====
// One storage cell of the message ring: holds a message and hands it on.
// Depends on bmb_pkg.
module bmb_cell (
   input  logic                  clock,
   input  bmb_pkg::cell_ctl_type ctl,
   input  logic                  head,
   input  bmb_pkg::msg_type      msg_prev,
   output bmb_pkg::msg_type      msg_out
);
   import bmb_pkg::*;

   msg_type msg_ff, msg_in;

   // advance the ring; the head cell marks its message as seen when told
   always_comb begin
      msg_in = msg_ff;
      if (ctl.shift) begin
         msg_in = msg_prev;
      end
      if (ctl.mark && head) begin
         msg_in = msg_ff;
         msg_in.seen[ctl.consumer] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
   end

   assign msg_out = msg_ff;
endmodule

// ===== rtl/broadcast_message_buffer.sv =====
// Broadcast message buffer: a ring of 16 message cells rotated one place a cycle while a
// request steps it, pausing for marks and decisions. An item is taken only while the block is
// idle and no result waits under stall. An enqueue first evicts the oldest message when the
// buffer is at its cap, then rotates the ring once per offset candidate, for up to 17
// candidates, and then rotates the new message into place and loads the result. A fetch
// rotates the ring once, marking each match as seen at the head and handing on each match but
// the last, then loads the final result; the result register waits under stall. The
// rotation through the cells sets the rate. No clearing pass is needed after reset.
// Depends on bmb_pkg and bmb_cell.
module broadcast_message_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_topic_id,
   input  logic [31:0] req_payload,
   input  logic [3:0]  req_consumer_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_out_topic,
   output logic [31:0] rsp_out_payload,
   output logic [31:0] rsp_out_offset,
   output logic        rsp_evicted,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import bmb_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EVICT = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_STORE = 6'b001000,
      ST_FETCH = 6'b010000,
      ST_SEND  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0]  max_msg_ff, max_msg_in;
   logic [31:0] max_off_ff, max_off_in;
   logic [CountW-1:0] held_ff, held_in;
   logic [31:0] ctr_ff, ctr_in;
   logic [31:0] cand_ff, cand_in;
   logic [CountW-1:0] pos_ff, pos_in;
   logic [CountW-1:0] tries_ff, tries_in;
   logic        hit_ff, hit_in;
   logic        ev_ff, ev_in;
   logic [7:0]  topic_ff, topic_in;
   logic [31:0] pay_ff, pay_in;
   logic [3:0]  cons_ff, cons_in;
   logic        ov_ff, ov_in;
   logic [1:0]  okind_ff, okind_in;
   logic [7:0]  otopic_ff, otopic_in;
   logic [31:0] opay_ff, opay_in;
   logic [31:0] ooff_ff, ooff_in;
   logic        oev_ff, oev_in;
   logic        olast_ff, olast_in;
   // pending delivery waiting for a later match or the end of the scan
   logic        pv_ff, pv_in;
   logic [31:0] ppay_ff, ppay_in;
   logic [31:0] poff_ff, poff_in;

   cell_ctl_type ctl;
   msg_type      cell_q [QueueDepth];
   msg_type      feed;
   logic [CountW-1:0] cap;
   logic        out_free;
   logic [31:0] bumped;
   msg_type     head;
   logic        fetch_hit;

   // cell 0 is the oldest held message; the ring turns towards it
   assign head = cell_q[0];

   genvar g;
   generate
      for (g = 0; g < QueueDepth; g++) begin : g_cell
         msg_type prev;
         if (g == QueueDepth - 1) begin : g_tail
            assign prev = feed;
         end else begin : g_mid
            assign prev = cell_q[g+1];
         end
         bmb_cell u_cell (
            .clock    (clock),
            .ctl      (ctl),
            .head     (g == 0),
            .msg_prev (prev),
            .msg_out  (cell_q[g])
         );
      end
   endgenerate

   // clamp the cap into one to the queue depth
   always_comb begin
      if (max_msg_ff == 5'd0) begin
         cap = CountW'(1);
      end else if (32'(max_msg_ff) > QueueDepth) begin
         cap = CountW'(QueueDepth);
      end else begin
         cap = CountW'(max_msg_ff);
      end
   end

   function automatic logic [31:0] bump(input logic [31:0] c, input logic [31:0] lim);
      logic [31:0] n;
      n = c + 32'd1;
      if (n == 32'd0 || n >= lim) begin
         n = 32'd1;
      end
      return n;
   endfunction

   assign bumped    = bump(cand_ff, max_off_ff);
   assign out_free  = !ov_ff || !rsp_stall;
   assign fetch_hit = (head.topic == topic_ff) && !head.seen[cons_ff];

   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      max_msg_in = max_msg_ff;
      max_off_in = max_off_ff;
      held_in = held_ff;
      ctr_in = ctr_ff;
      cand_in = cand_ff;
      pos_in = pos_ff;
      tries_in = tries_ff;
      hit_in = hit_ff;
      ev_in = ev_ff;
      topic_in = topic_ff;
      pay_in = pay_ff;
      cons_in = cons_ff;
      ov_in = ov_ff;
      okind_in = okind_ff;
      otopic_in = otopic_ff;
      opay_in = opay_ff;
      ooff_in = ooff_ff;
      oev_in = oev_ff;
      olast_in = olast_ff;
      pv_in = pv_ff;
      ppay_in = ppay_ff;
      poff_in = poff_ff;
      ctl = '0;
      ctl.consumer = cons_ff;
      ctl.topic = topic_ff;
      feed = head;

      if (ov_ff && !rsp_stall) begin
         ov_in = 1'b0;
      end

      // write configuration
      if (csr_valid) begin
         unique case (csr_index)
            REG_MAX_MESSAGES: max_msg_in = csr_data[4:0];
            REG_MAX_OFFSET:   max_off_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && out_free) begin
               topic_in = req_topic_id;
               pay_in = req_payload;
               cons_in = req_consumer_id;
               pos_in = '0;
               ev_in = 1'b0;
               pv_in = 1'b0;
               if (req_action == ACT_ENQ) begin
                  state_in = ST_EVICT;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_EVICT: begin
            // drop the oldest by one rotation step, leaving it outside the held window
            if (held_ff >= cap && held_ff != '0) begin
               ctl.shift = 1'b1;
               held_in = held_ff - CountW'(1);
               ev_in = 1'b1;
            end
            cand_in = bump(ctr_ff, max_off_ff);
            tries_in = '0;
            pos_in = '0;
            hit_in = 1'b0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // rotate the held window once, comparing each against the candidate
            if (pos_ff < held_ff) begin
               ctl.shift = 1'b1;
               feed = head;
               if (head.offset == cand_ff) begin
                  hit_in = 1'b1;
               end
               pos_in = pos_ff + CountW'(1);
            end else begin
               // realign: the window has come back round to the head
               if (held_ff != '0 && 32'(held_ff) != QueueDepth && pos_ff != '0 &&
                   pos_ff < CountW'(QueueDepth)) begin
                  ctl.shift = 1'b1;
                  feed = head;
                  pos_in = pos_ff + CountW'(1);
               end else if (hit_ff && 32'(tries_ff) < QueueDepth) begin
                  cand_in = bumped;
                  tries_in = tries_ff + CountW'(1);
                  hit_in = 1'b0;
                  pos_in = '0;
               end else begin
                  state_in = ST_STORE;
                  pos_in = '0;
               end
            end
         end
         ST_STORE: begin
            // place the new message just above the held window
            if (pos_ff < held_ff) begin
               ctl.shift = 1'b1;
               feed = head;
               pos_in = pos_ff + CountW'(1);
            end else if (pos_ff == held_ff) begin
               ctl.shift = 1'b1;
               feed.topic = topic_ff;
               feed.payload = pay_ff;
               feed.offset = cand_ff;
               feed.seen = '0;
               pos_in = pos_ff + CountW'(1);
            end else if (pos_ff < CountW'(QueueDepth)) begin
               ctl.shift = 1'b1;
               feed = head;
               pos_in = pos_ff + CountW'(1);
            end else if (out_free) begin
               held_in = held_ff + CountW'(1);
               ctr_in = cand_ff;
               ov_in = 1'b1;
               okind_in = KIND_ENQ;
               otopic_in = topic_ff;
               opay_in = '0;
               ooff_in = cand_ff;
               oev_in = ev_ff;
               olast_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            // visit each message at the head, mark it if it matches, then rotate
            if (pos_ff < held_ff) begin
               if (fetch_hit && !pv_ff && !ctl.mark) begin
                  ctl.mark = 1'b1;
                  pv_in = 1'b1;
                  ppay_in = head.payload;
                  poff_in = head.offset;
                  state_in = ST_SEND;
               end else begin
                  ctl.shift = 1'b1;
                  feed = head;
                  pos_in = pos_ff + CountW'(1);
               end
            end else if (pos_ff < CountW'(QueueDepth)) begin
               ctl.shift = 1'b1;
               feed = head;
               pos_in = pos_ff + CountW'(1);
            end else if (out_free) begin
               ov_in = 1'b1;
               olast_in = 1'b1;
               otopic_in = topic_ff;
               oev_in = 1'b0;
               if (pv_ff) begin
                  okind_in = KIND_DLV;
                  opay_in = ppay_ff;
                  ooff_in = poff_ff;
               end else begin
                  okind_in = KIND_NONE;
                  opay_in = '0;
                  ooff_in = '0;
               end
               pv_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_SEND: begin
            // hold the just-marked match and rotate past it
            ctl.shift = 1'b1;
            feed = head;
            pos_in = pos_ff + CountW'(1);
            state_in = ST_FETCH;
            pv_in = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase

      // when a second match is pending, flush the earlier one first
      if (state_ff == ST_FETCH && pos_ff < held_ff && fetch_hit && pv_ff) begin
         ctl.shift = 1'b0;
         feed = head;
         pos_in = pos_ff;
         state_in = ST_FETCH;
         if (out_free) begin
            ov_in = 1'b1;
            okind_in = KIND_DLV;
            otopic_in = topic_ff;
            opay_in = ppay_ff;
            ooff_in = poff_ff;
            oev_in = 1'b0;
            olast_in = 1'b0;
            pv_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         max_msg_ff <= 5'd16;
         max_off_ff <= 32'hFFFF_FFFF;
         held_ff <= '0;
         ctr_ff <= '0;
         ov_ff <= 1'b0;
         pv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         max_msg_ff <= max_msg_in;
         max_off_ff <= max_off_in;
         held_ff <= held_in;
         ctr_ff <= ctr_in;
         ov_ff <= ov_in;
         pv_ff <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      pos_ff <= pos_in;
      tries_ff <= tries_in;
      hit_ff <= hit_in;
      ev_ff <= ev_in;
      topic_ff <= topic_in;
      pay_ff <= pay_in;
      cons_ff <= cons_in;
      okind_ff <= okind_in;
      otopic_ff <= otopic_in;
      opay_ff <= opay_in;
      ooff_ff <= ooff_in;
      oev_ff <= oev_in;
      olast_ff <= olast_in;
      ppay_ff <= ppay_in;
      poff_ff <= poff_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_result_kind = okind_ff;
   assign rsp_out_topic = otopic_ff;
   assign rsp_out_payload = opay_ff;
   assign rsp_out_offset = ooff_ff;
   assign rsp_evicted = oev_ff;
   assign rsp_last = olast_ff;
endmodule

// ===== rtl/bmb_checker.sv =====
// Port checker for the broadcast message buffer, bound to the top level.
// Depends on bmb_pkg.
module bmb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_result_kind,
   input logic [31:0] rsp_out_payload,
   input logic [31:0] rsp_out_offset,
   input logic       rsp_evicted,
   input logic       rsp_last
);
   import bmb_pkg::*;

   // a stalled item stays valid and holds its offset
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_offset))
      else $error("result item changed under stall");

   // no new input while a result item waits
   a_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while a result item waits");

   // acknowledgements and empty fetches close their input
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_ENQ || rsp_result_kind == KIND_NONE) |-> rsp_last)
      else $error("single result without last");

   // only enqueues report eviction
   a_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> rsp_result_kind == KIND_ENQ)
      else $error("eviction flag on a fetch result");

   // an empty fetch carries a zero offset and a zero payload
   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_NONE |-> rsp_out_offset == 32'd0 &&
      rsp_out_payload == 32'd0)
      else $error("empty fetch carries data");
endmodule

bind broadcast_message_buffer bmb_checker u_bmb_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result_kind(rsp_result_kind),
   .rsp_out_payload(rsp_out_payload), .rsp_out_offset(rsp_out_offset),
   .rsp_evicted(rsp_evicted), .rsp_last(rsp_last)
);
